@@ hdl/waypoint_path_lookahead_defines.svh @@
// Assertion macros shared by the waypoint path lookahead design.
`ifndef WAYPOINT_PATH_LOOKAHEAD_DEFINES_SVH
`define WAYPOINT_PATH_LOOKAHEAD_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wpl_pkg.sv @@
// Shared types and constants of the waypoint path lookahead block.
package wpl_pkg;

    localparam int FIELD_BITS   = 10;
    localparam int HEAD_BITS    = 2;
    localparam int OUTCOME_BITS = 2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [OUTCOME_BITS-1:0] {
        OUT_REACHED = 2'd0,
        OUT_FOUND   = 2'd1,
        OUT_MISSED  = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK
    } t_state;

endpackage

@@ hdl/wpl_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module wpl_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/waypoint_path_lookahead.sv @@
// Top level of the waypoint path lookahead: stored grid path, pose search and run walk-back.
// A load beat is written straight from idle and busy never rises for it. A query with a
// match at index k scans entries 0 to k, then walks back over at most k earlier entries,
// one path memory read per cycle; a miss scans the whole path. The result strobe rises
// together with the fall of busy; results cannot be stalled by the receiver.
// Synchronous reset empties the path at once; memory contents stay undefined, no clear pass.
`include "waypoint_path_lookahead_defines.svh"

module waypoint_path_lookahead #(
    parameter int PATH_DEPTH = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [wpl_pkg::FIELD_BITS-1:0]    i_pos_x,
    input  logic [wpl_pkg::FIELD_BITS-1:0]    i_pos_y,
    input  logic [wpl_pkg::HEAD_BITS-1:0]     i_heading,
    input  logic                              i_new_path,
    output logic                              strobe,
    output wpl_pkg::t_outcome                 o_outcome,
    output logic [wpl_pkg::FIELD_BITS-1:0]    o_target_x,
    output logic [wpl_pkg::FIELD_BITS-1:0]    o_target_y,
    output logic [wpl_pkg::HEAD_BITS-1:0]     o_target_heading
);

    import wpl_pkg::*;

    // Address width of the path memory and width of the length counter, which must
    // be able to hold PATH_DEPTH itself.
    localparam int AW = $clog2(PATH_DEPTH);
    localparam int LW = $clog2(PATH_DEPTH + 1);
    // One stored waypoint is packed as {heading, y, x}.
    localparam int EW = 2 * COORD_BITS + HEAD_BITS;

    // Sequencer state. r_idx is the entry whose read data is on the RAM output in
    // the scan and walk states.
    t_state               r_state, n_state;
    logic [LW-1:0]        r_len,   n_len;
    logic [AW-1:0]        r_idx,   n_idx;
    logic [AW-1:0]        r_km1,   n_km1;
    logic [HEAD_BITS-1:0] r_kh,    n_kh;
    logic [EW-1:0]        r_prev,  n_prev;

    // Pose under search, already masked to the coordinate width.
    logic [COORD_BITS-1:0] r_px, n_px;
    logic [COORD_BITS-1:0] r_py, n_py;
    logic [HEAD_BITS-1:0]  r_ph, n_ph;

    // Result register: one beat per answered query.
    logic                  r_strobe, n_strobe;
    t_outcome              r_outcome, n_outcome;
    logic [FIELD_BITS-1:0] r_tx, n_tx;
    logic [FIELD_BITS-1:0] r_ty, n_ty;
    logic [HEAD_BITS-1:0]  r_th, n_th;

    // Path memory ports.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    // Fields of the entry currently read out of the memory.
    logic [COORD_BITS-1:0] w_rd_x;
    logic [COORD_BITS-1:0] w_rd_y;
    logic [HEAD_BITS-1:0]  w_rd_h;
    logic                  w_hit;

    // Masked input coordinates.
    logic [COORD_BITS-1:0] w_in_x;
    logic [COORD_BITS-1:0] w_in_y;

    // Result selection: which entry and which code go out when the query ends.
    logic          w_emit;
    logic [EW-1:0] w_emit_entry;
    t_outcome      w_emit_code;

    assign w_in_x = COORD_BITS'(i_pos_x);
    assign w_in_y = COORD_BITS'(i_pos_y);

    assign w_rd_x = w_rdata[COORD_BITS-1:0];
    assign w_rd_y = w_rdata[2*COORD_BITS-1:COORD_BITS];
    assign w_rd_h = w_rdata[EW-1:2*COORD_BITS];

    // The pose comparator: the read entry against the query pose.
    assign w_hit = (w_rd_x == r_px) && (w_rd_y == r_py) && (w_rd_h == r_ph);

    wpl_ram #(
        .WIDTH(EW),
        .DEPTH(PATH_DEPTH)
    ) u_path_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_strobe <= n_strobe;
        end
        r_idx     <= n_idx;
        r_km1     <= n_km1;
        r_kh      <= n_kh;
        r_prev    <= n_prev;
        r_px      <= n_px;
        r_py      <= n_py;
        r_ph      <= n_ph;
        r_outcome <= n_outcome;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_th      <= n_th;
    end

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_idx        = r_idx;
        n_km1        = r_km1;
        n_kh         = r_kh;
        n_prev       = r_prev;
        n_px         = r_px;
        n_py         = r_py;
        n_ph         = r_ph;
        n_strobe     = 1'b0;
        n_outcome    = r_outcome;
        n_tx         = r_tx;
        n_ty         = r_ty;
        n_th         = r_th;
        w_we         = 1'b0;
        w_waddr      = r_len[AW-1:0];
        w_wdata      = {i_heading, w_in_y, w_in_x};
        w_raddr      = r_idx;
        w_emit       = 1'b0;
        w_emit_entry = w_rdata;
        w_emit_code  = OUT_MISSED;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (t_op'(i_operation) == OP_LOAD) begin
                        // A new path restarts at the goal slot; a full path drops the beat.
                        if (i_new_path) begin
                            w_we    = 1'b1;
                            w_waddr = '0;
                            n_len   = LW'(1);
                        end else if (r_len < LW'(PATH_DEPTH)) begin
                            w_we  = 1'b1;
                            n_len = r_len + LW'(1);
                        end
                    end else if (r_len != '0) begin
                        // Query: latch the pose and start reading from the goal.
                        n_px    = w_in_x;
                        n_py    = w_in_y;
                        n_ph    = i_heading;
                        n_idx   = '0;
                        w_raddr = '0;
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (w_hit) begin
                    if (r_idx == '0) begin
                        w_emit      = 1'b1;
                        w_emit_code = OUT_REACHED;
                    end else begin
                        // Cut the path after the match and walk back along its heading run.
                        n_len   = LW'(r_idx) + LW'(1);
                        n_kh    = w_rd_h;
                        n_km1   = r_idx - AW'(1);
                        n_idx   = r_idx - AW'(1);
                        w_raddr = r_idx - AW'(1);
                        n_state = ST_WALK;
                    end
                end else if (LW'(r_idx) == r_len - LW'(1)) begin
                    // Last entry checked without a match: it is the answer.
                    w_emit      = 1'b1;
                    w_emit_code = OUT_MISSED;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    w_raddr = r_idx + AW'(1);
                end
            end

            ST_WALK: begin
                if (w_rd_h != r_kh) begin
                    // The run starts one entry later; the entry just before the match
                    // is the latest allowed choice.
                    w_emit       = 1'b1;
                    w_emit_code  = OUT_FOUND;
                    w_emit_entry = (r_idx == r_km1) ? w_rdata : r_prev;
                end else if (r_idx == '0) begin
                    w_emit      = 1'b1;
                    w_emit_code = OUT_FOUND;
                end else begin
                    n_prev  = w_rdata;
                    n_idx   = r_idx - AW'(1);
                    w_raddr = r_idx - AW'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit) begin
            n_strobe  = 1'b1;
            n_outcome = w_emit_code;
            n_tx      = FIELD_BITS'(w_emit_entry[COORD_BITS-1:0]);
            n_ty      = FIELD_BITS'(w_emit_entry[2*COORD_BITS-1:COORD_BITS]);
            n_th      = w_emit_entry[EW-1:2*COORD_BITS];
            n_state   = ST_IDLE;
        end
    end

    assign busy             = (r_state != ST_IDLE);
    assign strobe           = r_strobe;
    assign o_outcome        = r_outcome;
    assign o_target_x       = r_tx;
    assign o_target_y       = r_ty;
    assign o_target_heading = r_th;

    // A result beat always leaves the sequencer back in idle.
    `WPL_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, r_strobe,
        r_state == ST_IDLE, "result beat while busy")
    // A result beat only follows a query that was in progress.
    `WPL_ASSERT_NOW(a_strobe_after_query, i_clk, i_rst_n, r_strobe,
        $past(r_state) != ST_IDLE, "result beat without a query")
    // The stored length never exceeds the memory depth.
    `WPL_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1,
        r_len <= LW'(PATH_DEPTH), "path length beyond depth")
    // The walk-back never runs past the entry before the match.
    `WPL_ASSERT_NOW(a_walk_bound, i_clk, i_rst_n, r_state == ST_WALK,
        r_idx <= r_km1, "walk index past match")
    // The walk-back either continues or returns to idle, never back into the scan.
    `WPL_ASSERT_NEXT(a_walk_entry, i_clk, i_rst_n, r_state == ST_WALK,
        r_state != ST_SCAN, "walk fell back into scan")

endmodule
